// ===== sv/mexp_pkg.sv =====
// Package for the modular exponentiation block: field widths, reset constant,
// and the status bundle of the serial modular multiplier.
// No dependencies.
package mexp_pkg;

  localparam int BASE_W       = 31;
  localparam int EXP_IN_W     = 32;
  localparam int MODULUS_IN_W = 31;
  localparam int RESULT_W     = 31;

  localparam logic [MODULUS_IN_W-1:0] MODULUS_RESET = 31'd1000000007;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

// ===== sv/mexp_mulmod.sv =====
// Bit-serial interleaved modular multiplier: x * y mod m, one bit of x per cycle.
// Depends on mexp_pkg for the status bundle.
module mexp_mulmod #(
  parameter int W  = 31,
  parameter int XW = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [XW-1:0]       x,
  input  logic [W-1:0]        y,
  input  logic [W-1:0]        m,
  output logic [W-1:0]        product,
  output mexp_pkg::mm_status_t status
);
  import mexp_pkg::*;

  localparam int TW = W + 2;
  localparam int CW = $clog2(XW + 1);

  logic [XW-1:0] xs;
  logic [W-1:0]  yr;
  logic [W-1:0]  r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [TW-1:0] t;
  logic [TW-1:0] m1;
  logic [TW-1:0] m2;
  logic [W-1:0]  r_next;

  always_comb begin
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    t  = {1'b0, r, 1'b0} + (xs[XW-1] ? {2'b00, yr} : '0);
    priority if (t >= m2) begin
      r_next = W'(t - m2);
    end else if (t >= m1) begin
      r_next = W'(t - m1);
    end else begin
      r_next = W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(XW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs <= x;
      yr <= y;
      r  <= '0;
    end else if (busy) begin
      xs <= xs << 1;
      r  <= r_next;
    end
  end

  assign product     = r;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== sv/modular_exponentiation.sv =====
// Top level: right-to-left square-and-multiply over a shared bit-serial multiplier.
// Depends on mexp_pkg and mexp_mulmod.
//
// channel  direction  handshake                 payload
// item     in         item_valid / item_stall   base_value, exponent
// result   out        result_valid / result_stall power_result
// cfg      in         cfg_valid / cfg_ready     modulus
//
// The serial multiplier steps through the XW = max(MOD_BITS, 31) bits of its x operand.
// An item takes one base reduction plus one multiply per set exponent bit and one
// square per exponent bit below the top set bit. A modulus of 0 or 1 yields 0
// without using the multiplier. Reset is synchronous and leaves the modulus at
// 1000000007. A finished result waits in the output register while a new item is
// taken; the sequencer holds only if that register is still full.
module modular_exponentiation #(
  parameter int EXP_BITS = 32,
  parameter int MOD_BITS = 31
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [mexp_pkg::BASE_W-1:0]       base_value,
  input  logic [mexp_pkg::EXP_IN_W-1:0]     exponent,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [mexp_pkg::RESULT_W-1:0]     power_result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mexp_pkg::MODULUS_IN_W-1:0] modulus
);
  import mexp_pkg::*;

  localparam int W  = MOD_BITS;
  localparam int XW = (MOD_BITS > BASE_W) ? MOD_BITS : BASE_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_BASE = 6'b000010,
    S_STEP = 6'b000100,
    S_MUL  = 6'b001000,
    S_SQR  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t              state, state_next;
  logic [W-1:0]        mod_reg;
  logic [W-1:0]        sq, sq_next;
  logic [W-1:0]        acc, acc_next;
  logic [EXP_BITS-1:0] exp_reg, exp_next;
  logic [W-1:0]        res, res_next;

  logic                mm_start;
  logic [XW-1:0]       mm_x;
  logic [W-1:0]        mm_y;
  logic [W-1:0]        mm_prod;
  mm_status_t          mm_stat;

  logic [63:0]         exp_wide;
  logic [63:0]         mod_wide;
  logic [63:0]         res_wide;
  logic                item_take;
  logic                mod_small;
  logic                out_free;

  assign exp_wide  = 64'(exponent);
  assign mod_wide  = 64'(modulus);
  assign res_wide  = 64'(res);
  assign item_stall = (state != S_IDLE);
  assign item_take = item_valid && !item_stall;
  assign mod_small = (mod_reg < W'(2));
  assign out_free  = !result_valid || !result_stall;
  assign cfg_ready = 1'b1;

  mexp_mulmod #(.W(W), .XW(XW)) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .x       (mm_x),
    .y       (mm_y),
    .m       (mod_reg),
    .product (mm_prod),
    .status  (mm_stat)
  );

  always_comb begin
    state_next = state;
    sq_next    = sq;
    acc_next   = acc;
    exp_next   = exp_reg;
    res_next   = res;
    mm_start   = 1'b0;
    mm_x       = (state == S_IDLE) ? XW'(base_value)
               : ((state == S_STEP) && exp_reg[0]) ? XW'(acc) : XW'(sq);
    mm_y       = (state == S_IDLE) ? W'(1) : sq;
    unique case (state)
      S_IDLE: begin
        if (item_take) begin
          exp_next = exp_wide[EXP_BITS-1:0];
          if (mod_small) begin
            res_next   = '0;
            state_next = S_DONE;
          end else begin
            mm_start   = 1'b1;
            state_next = S_BASE;
          end
        end
      end
      S_BASE: begin
        if (mm_stat.done) begin
          sq_next    = mm_prod;
          acc_next   = W'(1);
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (exp_reg == '0) begin
          res_next   = acc;
          state_next = S_DONE;
        end else if (exp_reg[0]) begin
          mm_start   = 1'b1;
          state_next = S_MUL;
        end else begin
          mm_start   = 1'b1;
          exp_next   = exp_reg >> 1;
          state_next = S_SQR;
        end
      end
      S_MUL: begin
        if (mm_stat.done) begin
          acc_next = mm_prod;
          exp_next = exp_reg >> 1;
          if ((exp_reg >> 1) == '0) begin
            res_next   = mm_prod;
            state_next = S_DONE;
          end else begin
            mm_start   = 1'b1;
            state_next = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mm_stat.done) begin
          sq_next    = mm_prod;
          state_next = S_STEP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mod_reg      <= W'(MODULUS_RESET);
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        mod_reg <= mod_wide[W-1:0];
      end
      if ((state == S_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sq      <= sq_next;
    acc     <= acc_next;
    exp_reg <= exp_next;
    res     <= res_next;
    if ((state == S_DONE) && out_free) begin
      power_result <= res_wide[RESULT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result beat raised outside completion");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    mm_stat.done |-> (state == S_BASE || state == S_MUL || state == S_SQR))
    else $error("multiplier finished with no product pending");

  a_start_on_take: assert property (@(posedge clk) disable iff (rst)
    (item_take && !mod_small) |=> mm_stat.busy)
    else $error("base reduction did not start");

  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (acc < mod_reg && sq < mod_reg))
    else $error("operand not reduced modulo the modulus");
`endif

endmodule
